// ===== rtl/fwbf_pkg.sv =====
// Shared constants, stage record and helper functions for the FENE/WCA bond force pipeline.
`timescale 1ns / 1ps

package fwbf_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_MAX_BOND_LENGTH = 3'd0;
    localparam logic [2:0] REG_SPRING_CONSTANT = 3'd1;
    localparam logic [2:0] REG_LJ_SIGMA        = 3'd2;
    localparam logic [2:0] REG_LJ_EPSILON      = 3'd3;
    localparam logic [2:0] REG_ENERGY_ENABLE   = 3'd4;
    localparam logic [2:0] REG_NEWTON_MODE     = 3'd5;

    // Register reset values
    localparam logic [31:0] RST_MAX_BOND_LENGTH = 32'd25165824;
    localparam logic [31:0] RST_SPRING_CONSTANT = 32'd1966080;
    localparam logic [31:0] RST_LJ_SIGMA        = 32'd16777216;
    localparam logic [31:0] RST_LJ_EPSILON      = 32'd65536;

    // Fixed-point constants
    localparam logic [63:0] Q32_ONE       = 64'h0000_0001_0000_0000;
    localparam logic [63:0] SAT63         = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ARG_FLOOR     = 64'd429496730;
    localparam logic [63:0] CBRT2_Q32     = 64'h0000_0001_428A_2F99;
    localparam logic [63:0] LN2_Q32       = 64'h0000_0000_B172_17F8;
    localparam logic [63:0] POS48         = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] NEG48         = 64'h0000_8000_0000_0000;
    localparam logic [63:0] QUOT_CAP      = 64'h0000_0100_0000_0000;
    localparam logic [63:0] BAD_LIMIT     = 64'h0000_0004_0000_0000;
    localparam logic [63:0] STRETCH_LIMIT = Q32_ONE - ARG_FLOOR;
    localparam logic [63:0] HALF_Q32      = Q32_ONE >> 1;
    localparam logic [63:0] T3_LIMIT      = SAT63 / 64'd24;

    // Pipeline geometry
    localparam int DIV_STEPS = 112;
    localparam int MUL_LAT   = 2;
    localparam int LOG_STEPS = 32;
    localparam int ST_DIST   = 2;
    localparam int ST_NEAR   = 10;
    localparam int ST_ARG    = ST_DIST + DIV_STEPS + 1;
    localparam int ST_MANT   = ST_ARG + 1;
    localparam int ST_INV4   = ST_ARG + MUL_LAT + 1;
    localparam int ST_INV6   = ST_INV4 + MUL_LAT + 1;
    localparam int ST_T1     = ST_INV6 + MUL_LAT + 1;
    localparam int ST_T3     = ST_T1 + MUL_LAT + 1;
    localparam int ST_NL2    = ST_MANT + LOG_STEPS + 1;
    localparam int ST_NL     = ST_NL2 + MUL_LAT + 1;
    localparam int ST_EFENE  = ST_NL + MUL_LAT + 1;
    localparam int ST_FENE   = ST_ARG + DIV_STEPS + 1;
    localparam int ST_WCA    = ST_T3 + DIV_STEPS + 1;
    localparam int ST_SUM    = ST_WCA + 1;
    localparam int ST_LAST   = ST_SUM + MUL_LAT;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_CLAMPED = 2'd1,
        STATUS_BAD     = 2'd2
    } status_t;

    // Per-item record carried down the main pipeline
    typedef struct packed {
        logic [2:0][32:0] d;
        logic [1:0]       app;
        logic [63:0]      dist2;
        logic             near;
        logic             bad;
        status_t          status;
        logic [32:0]      arg;
        logic [32:0]      mant;
        logic [2:0]       ipart;
        logic [31:0]      frac;
        logic [34:0]      nl2;
        logic [63:0]      nl;
        logic [63:0]      efene;
        logic [63:0]      inv2;
        logic [63:0]      inv4;
        logic [63:0]      inv6;
        logic [63:0]      edg;
        logic [63:0]      t1;
        logic [63:0]      ee;
        logic [63:0]      t3;
        logic [63:0]      ewca;
        logic [63:0]      fene;
        logic [63:0]      wca;
        logic             sneg;
        logic [63:0]      smag;
        logic [47:0]      energy;
    } stage_t;

    // Shift a product right and clamp it to a cap
    function automatic logic [63:0] shr_sat(input logic [127:0] p, input int unsigned sh,
                                            input logic [63:0] cap);
        logic [127:0] v;
        v = p >> sh;
        if (v > {64'b0, cap})
            return cap;
        return v[63:0];
    endfunction

    // Clamp a divider quotient to a cap
    function automatic logic [63:0] div_sat(input logic [63:0] q, input logic ovf,
                                            input logic [63:0] cap);
        if (ovf || (q > cap))
            return cap;
        return q;
    endfunction

    // Magnitude of a 33-bit signed difference
    function automatic logic [31:0] mag33(input logic [32:0] v);
        logic [32:0] n;
        n = ~v + 33'd1;
        return v[32] ? n[31:0] : v[31:0];
    endfunction

endpackage

// ===== rtl/fwbf_mul.sv =====
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
`timescale 1ns / 1ps

module fwbf_mul (
    input  logic         clk,
    input  logic         ce,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] p
);

    logic [63:0]  pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [127:0] p_reg;
    logic [127:0] p_next;

    // Sum the registered partial products
    always_comb
    begin
        p_next = {64'b0, pp00_reg} + {32'b0, pp01_reg, 32'b0}
               + {32'b0, pp10_reg, 32'b0} + {pp11_reg, 64'b0};
    end

    // Form partial products, then the full product
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pp00_reg <= 64'(a[31:0]) * 64'(b[31:0]);
            pp01_reg <= 64'(a[31:0]) * 64'(b[63:32]);
            pp10_reg <= 64'(a[63:32]) * 64'(b[31:0]);
            pp11_reg <= 64'(a[63:32]) * 64'(b[63:32]);
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/fwbf_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, 112-bit dividend, 64-bit divisor.
`timescale 1ns / 1ps

module fwbf_div (
    input  logic         clk,
    input  logic         ce,
    input  logic [111:0] dvd,
    input  logic [63:0]  den,
    output logic [63:0]  quo,
    output logic         ovf
);

    localparam int N = fwbf_pkg::DIV_STEPS;

    logic [63:0]  rem_reg [0:N-1];
    logic [111:0] dvd_reg [0:N-1];
    logic [63:0]  den_reg [0:N-1];
    logic [63:0]  q_reg   [0:N-1];
    logic         ov_reg  [0:N-1];
    logic [63:0]  rem_next [0:N-1];
    logic [111:0] dvd_next [0:N-1];
    logic [63:0]  den_next [0:N-1];
    logic [63:0]  q_next   [0:N-1];
    logic         ov_next  [0:N-1];

    // One compare and subtract per stage; flag quotient bits beyond 64
    always_comb
    begin
        logic [63:0]  rp;
        logic [111:0] dp;
        logic [63:0]  dn;
        logic [63:0]  qp;
        logic         op;
        logic [64:0]  part;
        logic         qb;
        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                rp = 64'b0;
                dp = dvd;
                dn = den;
                qp = 64'b0;
                op = 1'b0;
            end
            else
            begin
                rp = rem_reg[k-1];
                dp = dvd_reg[k-1];
                dn = den_reg[k-1];
                qp = q_reg[k-1];
                op = ov_reg[k-1];
            end
            part = {rp, dp[111]};
            qb   = 1'b0;
            if (part >= {1'b0, dn})
            begin
                part = part - {1'b0, dn};
                qb   = 1'b1;
            end
            rem_next[k] = part[63:0];
            dvd_next[k] = {dp[110:0], 1'b0};
            den_next[k] = dn;
            q_next[k]   = {qp[62:0], qb};
            ov_next[k]  = op | qp[63];
        end
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < N; k++)
            begin
                rem_reg[k] <= rem_next[k];
                dvd_reg[k] <= dvd_next[k];
                den_reg[k] <= den_next[k];
                q_reg[k]   <= q_next[k];
                ov_reg[k]  <= ov_next[k];
            end
        end
    end

    assign quo = q_reg[N-1];
    assign ovf = ov_reg[N-1];

endmodule

// ===== rtl/fene_wca_bond_force_core.sv =====
// Top level of the FENE bond force engine with WCA repulsion.
//
// Usage: each request on the s_ side is one bond (two Q16.16 atom positions
// in s_tdata, locality flags in s_tuser). Each result on the m_ side carries
// the Q24.24 force on atom one and the bond energy in m_tdata, and the apply
// flags and status in m_tuser. Exactly one result per bond, in order.
// Throughput: one bond per cycle while the pipeline is not stalled. The path from
// accept to result valid is set by the WCA path: two distance stages, the 112-stage
// sigma^2/r2 divider, four multiplier steps, the 112-stage WCA scalar divider,
// the net-scalar stage, the force multiplier and the output register.
// The whole pipeline advances together; when m_tready is low with a result
// waiting, every stage holds and s_tready drops, so nothing is lost.
// Configuration: cfg_we writes cfg_data into register cfg_idx; write only
// while no bond is in flight. Derived squares and products of the registers
// settle after a write, through their own registers and multipliers.
// Reset: rst_n clears all valid bits and loads register defaults.
`timescale 1ns / 1ps

module fene_wca_bond_force_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_pos_x, first_pos_y, first_pos_z, second_pos_x, second_pos_y, second_pos_z
    input  logic [191:0] s_tdata,
    // first_local, second_local
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // force_x, force_y, force_z, bond_energy
    output logic [191:0] m_tdata,
    // apply_first, apply_second, status
    output logic [3:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_idx,
    input  logic [31:0]  cfg_data
);

    localparam int LAST = fwbf_pkg::ST_LAST;

    logic [31:0] r0_reg, k_reg, sig_reg, eps_reg;
    logic        een_reg, newton_reg;
    logic [63:0] ext2_reg, sig2_reg, lim_reg, kr2_reg;
    logic [127:0] lim_p, kr2_p;

    logic            ce;
    logic            vld_reg [0:LAST];
    fwbf_pkg::stage_t s_reg  [0:LAST];
    fwbf_pkg::stage_t s_next [0:LAST];
    logic [63:0]     sq_reg [0:2];

    logic [63:0]  quot_q, inv_q, fene_q, wca_q;
    logic         quot_ov, inv_ov, fene_ov, wca_ov;
    logic [127:0] pa, pb, pc, pd, pe, pf, pg, ph;
    logic [127:0] px [0:2];

    logic         out_valid_reg;
    logic [191:0] out_data_reg, out_data_next;
    logic [3:0]   out_user_reg;

    // Advance the pipeline unless a result waits on a stalled receiver
    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0_reg     <= fwbf_pkg::RST_MAX_BOND_LENGTH;
            k_reg      <= fwbf_pkg::RST_SPRING_CONSTANT;
            sig_reg    <= fwbf_pkg::RST_LJ_SIGMA;
            eps_reg    <= fwbf_pkg::RST_LJ_EPSILON;
            een_reg    <= 1'b0;
            newton_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                fwbf_pkg::REG_MAX_BOND_LENGTH: r0_reg     <= cfg_data;
                fwbf_pkg::REG_SPRING_CONSTANT: k_reg      <= cfg_data;
                fwbf_pkg::REG_LJ_SIGMA:        sig_reg    <= cfg_data;
                fwbf_pkg::REG_LJ_EPSILON:      eps_reg    <= cfg_data;
                fwbf_pkg::REG_ENERGY_ENABLE:   een_reg    <= cfg_data[0];
                fwbf_pkg::REG_NEWTON_MODE:     newton_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Derived register values: squares, WCA range limit, k*r0^2
    always_ff @(posedge clk)
    begin
        ext2_reg <= 64'(r0_reg) * 64'(r0_reg);
        sig2_reg <= 64'(sig_reg) * 64'(sig_reg);
        lim_reg  <= fwbf_pkg::shr_sat(lim_p, 48, fwbf_pkg::SAT63);
        kr2_reg  <= fwbf_pkg::shr_sat(kr2_p, 40, fwbf_pkg::SAT63);
    end

    fwbf_mul u_mul_lim (.clk(clk), .ce(1'b1), .a(sig2_reg), .b(fwbf_pkg::CBRT2_Q32), .p(lim_p));
    fwbf_mul u_mul_kr2 (.clk(clk), .ce(1'b1), .a({32'b0, k_reg}), .b(ext2_reg), .p(kr2_p));

    // Bond-length quotient r2/r0^2 and WCA ratio sigma^2/r2
    fwbf_div u_div_quot (
        .clk(clk), .ce(ce),
        .dvd({s_reg[fwbf_pkg::ST_DIST].dist2, 48'b0}), .den(ext2_reg),
        .quo(quot_q), .ovf(quot_ov)
    );
    fwbf_div u_div_inv (
        .clk(clk), .ce(ce),
        .dvd({32'b0, sig2_reg, 16'b0}), .den(s_reg[fwbf_pkg::ST_DIST].dist2),
        .quo(inv_q), .ovf(inv_ov)
    );

    // FENE scalar k/a
    fwbf_div u_div_fene (
        .clk(clk), .ce(ce),
        .dvd({32'b0, k_reg, 48'b0}), .den({31'b0, s_reg[fwbf_pkg::ST_ARG].arg}),
        .quo(fene_q), .ovf(fene_ov)
    );

    // WCA scalar t3/r2
    fwbf_div u_div_wca (
        .clk(clk), .ce(ce),
        .dvd({16'b0, s_reg[fwbf_pkg::ST_T3].t3, 32'b0}),
        .den(s_reg[fwbf_pkg::ST_T3].dist2),
        .quo(wca_q), .ovf(wca_ov)
    );

    // WCA products
    fwbf_mul u_mul_a (.clk(clk), .ce(ce), .a(s_reg[fwbf_pkg::ST_ARG].inv2),
                      .b(s_reg[fwbf_pkg::ST_ARG].inv2), .p(pa));
    fwbf_mul u_mul_b (.clk(clk), .ce(ce), .a(s_reg[fwbf_pkg::ST_INV4].inv4),
                      .b(s_reg[fwbf_pkg::ST_INV4].inv2), .p(pb));
    fwbf_mul u_mul_c (.clk(clk), .ce(ce), .a(s_reg[fwbf_pkg::ST_INV6].inv6),
                      .b(s_reg[fwbf_pkg::ST_INV6].edg), .p(pc));
    fwbf_mul u_mul_d (.clk(clk), .ce(ce), .a(s_reg[fwbf_pkg::ST_INV6].edg),
                      .b(s_reg[fwbf_pkg::ST_INV6].edg), .p(pd));
    fwbf_mul u_mul_e (.clk(clk), .ce(ce), .a(s_reg[fwbf_pkg::ST_T1].t1),
                      .b({32'b0, eps_reg}), .p(pe));
    fwbf_mul u_mul_f (.clk(clk), .ce(ce), .a(s_reg[fwbf_pkg::ST_T1].ee),
                      .b({32'b0, eps_reg}), .p(pf));

    // FENE energy products
    fwbf_mul u_mul_g (.clk(clk), .ce(ce), .a({29'b0, s_reg[fwbf_pkg::ST_NL2].nl2}),
                      .b(fwbf_pkg::LN2_Q32), .p(pg));
    fwbf_mul u_mul_h (.clk(clk), .ce(ce), .a(kr2_reg),
                      .b(s_reg[fwbf_pkg::ST_NL].nl), .p(ph));

    // Force components: |d| times scalar magnitude
    for (genvar gi = 0; gi < 3; gi++)
    begin : g_force
        fwbf_mul u_mul_f (
            .clk(clk), .ce(ce),
            .a({32'b0, fwbf_pkg::mag33(s_reg[fwbf_pkg::ST_SUM].d[gi])}),
            .b(s_reg[fwbf_pkg::ST_SUM].smag), .p(px[gi])
        );
    end

    // Stage logic: copy each record forward and fill in results as they land
    always_comb
    begin
        logic [65:0]  dsum;
        logic [63:0]  qs;
        logic [63:0]  v6;
        logic [63:0]  t2;
        logic [2:0]   nsh;
        logic [65:0]  sqp;
        logic [33:0]  m2;
        logic [63:0]  wv;
        logic [63:0]  fv;
        logic [64:0]  esum;

        for (int i = 1; i <= LAST; i++)
            s_next[i] = s_reg[i-1];

        // Input: coordinate differences and apply flags
        s_next[0]      = '0;
        s_next[0].d[0] = {s_tdata[31], s_tdata[31:0]} - {s_tdata[127], s_tdata[127:96]};
        s_next[0].d[1] = {s_tdata[63], s_tdata[63:32]} - {s_tdata[159], s_tdata[159:128]};
        s_next[0].d[2] = {s_tdata[95], s_tdata[95:64]} - {s_tdata[191], s_tdata[191:160]};
        s_next[0].app  = {newton_reg | s_tuser[1], newton_reg | s_tuser[0]};

        // Saturating sum of squares
        dsum = {2'b0, sq_reg[0]} + {2'b0, sq_reg[1]} + {2'b0, sq_reg[2]};
        s_next[fwbf_pkg::ST_DIST].dist2 = (dsum[65:64] != 2'b0) ? {64{1'b1}} : dsum[63:0];

        // WCA range test
        s_next[fwbf_pkg::ST_NEAR].near = s_reg[fwbf_pkg::ST_NEAR-1].dist2 < lim_reg;

        // Classify bond and form the clamped log argument
        qs = fwbf_pkg::div_sat(quot_q, quot_ov, fwbf_pkg::QUOT_CAP);
        s_next[fwbf_pkg::ST_ARG].inv2 = fwbf_pkg::div_sat(inv_q, inv_ov, fwbf_pkg::SAT63);
        priority if (qs >= fwbf_pkg::BAD_LIMIT)
        begin
            s_next[fwbf_pkg::ST_ARG].bad    = 1'b1;
            s_next[fwbf_pkg::ST_ARG].status = fwbf_pkg::STATUS_BAD;
            s_next[fwbf_pkg::ST_ARG].arg    = fwbf_pkg::ARG_FLOOR[32:0];
        end
        else if (qs > fwbf_pkg::STRETCH_LIMIT)
        begin
            s_next[fwbf_pkg::ST_ARG].bad    = 1'b0;
            s_next[fwbf_pkg::ST_ARG].status = fwbf_pkg::STATUS_CLAMPED;
            s_next[fwbf_pkg::ST_ARG].arg    = fwbf_pkg::ARG_FLOOR[32:0];
        end
        else
        begin
            s_next[fwbf_pkg::ST_ARG].bad    = 1'b0;
            s_next[fwbf_pkg::ST_ARG].status = fwbf_pkg::STATUS_OK;
            s_next[fwbf_pkg::ST_ARG].arg    = 33'(fwbf_pkg::Q32_ONE - qs);
        end

        // WCA chain
        s_next[fwbf_pkg::ST_INV4].inv4 = fwbf_pkg::shr_sat(pa, 32, fwbf_pkg::SAT63);
        v6 = fwbf_pkg::shr_sat(pb, 32, fwbf_pkg::SAT63);
        s_next[fwbf_pkg::ST_INV6].inv6 = v6;
        s_next[fwbf_pkg::ST_INV6].edg  = (v6 > fwbf_pkg::HALF_Q32) ?
                                         ((v6 << 1) - fwbf_pkg::Q32_ONE) : 64'b0;
        s_next[fwbf_pkg::ST_T1].t1 = fwbf_pkg::shr_sat(pc, 32, fwbf_pkg::SAT63);
        s_next[fwbf_pkg::ST_T1].ee = fwbf_pkg::shr_sat(pd, 32, fwbf_pkg::SAT63);
        t2 = fwbf_pkg::shr_sat(pe, 16, fwbf_pkg::SAT63);
        s_next[fwbf_pkg::ST_T3].t3   = (t2 > fwbf_pkg::T3_LIMIT) ? fwbf_pkg::SAT63 :
                                       t2 * 64'd24;
        s_next[fwbf_pkg::ST_T3].ewca = fwbf_pkg::shr_sat(pf, 24, fwbf_pkg::SAT63);

        // Normalize the log argument into [1, 2)
        priority if (s_reg[fwbf_pkg::ST_ARG].arg[32])
            nsh = 3'd0;
        else if (s_reg[fwbf_pkg::ST_ARG].arg[31])
            nsh = 3'd1;
        else if (s_reg[fwbf_pkg::ST_ARG].arg[30])
            nsh = 3'd2;
        else if (s_reg[fwbf_pkg::ST_ARG].arg[29])
            nsh = 3'd3;
        else
            nsh = 3'd4;
        s_next[fwbf_pkg::ST_MANT].mant  = s_reg[fwbf_pkg::ST_ARG].arg << nsh;
        s_next[fwbf_pkg::ST_MANT].ipart = nsh;
        s_next[fwbf_pkg::ST_MANT].frac  = 32'b0;

        // Bitwise log2: one squaring per stage
        for (int j = 0; j < fwbf_pkg::LOG_STEPS; j++)
        begin
            sqp = 66'(s_reg[fwbf_pkg::ST_MANT+j].mant) * 66'(s_reg[fwbf_pkg::ST_MANT+j].mant);
            m2  = sqp[65:32];
            s_next[fwbf_pkg::ST_MANT+j+1].mant = m2[33] ? m2[33:1] : m2[32:0];
            s_next[fwbf_pkg::ST_MANT+j+1].frac = {s_reg[fwbf_pkg::ST_MANT+j].frac[30:0], m2[33]};
        end

        s_next[fwbf_pkg::ST_NL2].nl2 = {s_reg[fwbf_pkg::ST_NL2-1].ipart, 32'b0}
                                     - {3'b0, s_reg[fwbf_pkg::ST_NL2-1].frac};
        s_next[fwbf_pkg::ST_NL].nl       = fwbf_pkg::shr_sat(pg, 32, fwbf_pkg::SAT63);
        s_next[fwbf_pkg::ST_EFENE].efene = fwbf_pkg::shr_sat(ph, 33, fwbf_pkg::SAT63);

        // Scalars land
        s_next[fwbf_pkg::ST_FENE].fene = fwbf_pkg::div_sat(fene_q, fene_ov, fwbf_pkg::SAT63);
        s_next[fwbf_pkg::ST_WCA].wca   = s_reg[fwbf_pkg::ST_WCA-1].near ?
                                         fwbf_pkg::div_sat(wca_q, wca_ov, fwbf_pkg::SAT63) :
                                         64'b0;

        // Net scalar and energy
        wv = s_reg[fwbf_pkg::ST_WCA].wca;
        fv = s_reg[fwbf_pkg::ST_WCA].fene;
        s_next[fwbf_pkg::ST_SUM].sneg = wv < fv;
        s_next[fwbf_pkg::ST_SUM].smag = (wv < fv) ? (fv - wv) : (wv - fv);
        esum = {1'b0, s_reg[fwbf_pkg::ST_WCA].efene}
             + {1'b0, s_reg[fwbf_pkg::ST_WCA].near ? s_reg[fwbf_pkg::ST_WCA].ewca : 64'b0};
        if (een_reg && !s_reg[fwbf_pkg::ST_WCA].bad)
            s_next[fwbf_pkg::ST_SUM].energy = (esum > {1'b0, fwbf_pkg::POS48}) ?
                                              fwbf_pkg::POS48[47:0] : esum[47:0];
        else
            s_next[fwbf_pkg::ST_SUM].energy = 48'b0;
    end

    // Pipeline registers
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i <= LAST; i++)
                s_reg[i] <= s_next[i];
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= 64'(fwbf_pkg::mag33(s_reg[0].d[i]))
                           * 64'(fwbf_pkg::mag33(s_reg[0].d[i]));
        end
    end

    // Valid bits travel with the records
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAST; i++)
                vld_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i <= LAST; i++)
                vld_reg[i] <= vld_reg[i-1];
            out_valid_reg <= vld_reg[LAST];
        end
    end

    // Signed, saturated force components; zero for a bad bond
    always_comb
    begin
        logic [63:0] mag;
        logic [47:0] neg;
        logic [47:0] fc;
        for (int i = 0; i < 3; i++)
        begin
            mag = fwbf_pkg::shr_sat(px[i], 24, fwbf_pkg::NEG48);
            neg = 48'(~mag + 64'd1);
            if (s_reg[LAST].bad)
                fc = 48'b0;
            else if (s_reg[LAST].d[i][32] != s_reg[LAST].sneg)
                fc = neg;
            else
                fc = (mag > fwbf_pkg::POS48) ? fwbf_pkg::POS48[47:0] : mag[47:0];
            out_data_next[i*48 +: 48] = fc;
        end
        out_data_next[191:144] = s_reg[LAST].energy;
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= {s_reg[LAST].status, s_reg[LAST].app};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
